### src/bqbc_pkg.sv
// ----------------------------------------------------------------------------
// bqbc_pkg
// Shared types, constants and helpers of the bracket and quote balance checker.
// ----------------------------------------------------------------------------
package bqbc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = 16;
  localparam int CODE_W      = 3;
  localparam int TDATA_W     = 32;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

  // Result codes
  localparam logic [CODE_W-1:0] CODE_CLOSER   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_OPENER   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SQ_OPEN  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DQ_OPEN  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OVERFLOW = 3'd4;
  localparam logic [CODE_W-1:0] CODE_SUMMARY  = 3'd5;

  // Character constants
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;
  localparam logic [7:0] CH_LANG   = 8'h3C;
  localparam logic [7:0] CH_RANG   = 8'h3E;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;       // process the accepted byte
    logic pop;        // report and drop the top opener
    logic sq_clear;   // report an open single quote
    logic dq_clear;   // report an open double quote
    logic summary;    // report the summary and clear for the next string
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;   // output register holds an item
    logic stack_empty;
    logic in_sq;
    logic in_dq;
  } status_t;

  // Matching opener of a closing bracket, zero for any other byte
  function automatic logic [7:0] opener_of(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_RPAR: r = CH_LPAR;
      CH_RBRK: r = CH_LBRK;
      CH_RBRC: r = CH_LBRC;
      CH_RANG: r = CH_LANG;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_LBRK) || (c == CH_LBRC) || (c == CH_LANG);
  endfunction

endpackage

### src/bqbc_dp.sv
// ----------------------------------------------------------------------------
// bqbc_dp
// Datapath: opener stack, quote flags, byte index and the output register.
// ----------------------------------------------------------------------------
module bqbc_dp
  import bqbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [7:0]        ch,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_code,
  output logic [7:0]        out_bracket,
  output logic [POS_W-1:0]  out_position,
  output logic              out_all_valid,
  output logic              out_last
);

  logic [7:0]       stk_char [STACK_DEPTH];
  logic [POS_W-1:0] stk_pos  [STACK_DEPTH];
  logic [CNT_W-1:0] stack_count;
  logic [POS_W-1:0] byte_index;
  logic             in_sq;
  logic             in_dq;
  logic             valid_so_far;

  logic [PTR_W-1:0] top_idx;
  logic [PTR_W-1:0] push_idx;
  logic [7:0]       want;
  logic             is_sq_tog;
  logic             is_dq_tog;
  logic             bracket_on;
  logic             closer_bad;
  logic             closer_ok;
  logic             push_full;
  logic             push_ok;

  assign top_idx    = PTR_W'(stack_count - 1'b1);
  assign push_idx   = PTR_W'(stack_count);
  assign want       = opener_of(ch);
  assign is_sq_tog  = (ch == CH_SQUOTE) && !in_dq;
  assign is_dq_tog  = (ch == CH_DQUOTE) && !in_sq;
  assign bracket_on = !is_sq_tog && !is_dq_tog && !in_sq && !in_dq;
  assign closer_bad = bracket_on && (want != 8'h00) &&
                      ((stack_count == '0) || (stk_char[top_idx] != want));
  assign closer_ok  = bracket_on && (want != 8'h00) && !closer_bad;
  assign push_full  = bracket_on && is_opener(ch) && (stack_count == STACK_FULL);
  assign push_ok    = bracket_on && is_opener(ch) && (stack_count != STACK_FULL);

  assign status.out_busy    = out_valid;
  assign status.stack_empty = (stack_count == '0);
  assign status.in_sq       = in_sq;
  assign status.in_dq       = in_dq;

  // Stack storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.take && push_ok) begin
      stk_char[push_idx] <= ch;
      stk_pos[push_idx]  <= byte_index;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= '0;
      byte_index   <= '0;
      in_sq        <= 1'b0;
      in_dq        <= 1'b0;
      valid_so_far <= 1'b1;
    end else if (cmd.take) begin
      if (byte_index != POS_MAX) begin
        byte_index <= byte_index + 1'b1;
      end
      if (is_sq_tog) begin
        in_sq <= !in_sq;
      end else if (is_dq_tog) begin
        in_dq <= !in_dq;
      end
      if (closer_ok) begin
        stack_count <= stack_count - 1'b1;
      end else if (push_ok) begin
        stack_count <= stack_count + 1'b1;
      end
      if (closer_bad || push_full) begin
        valid_so_far <= 1'b0;
      end
    end else if (cmd.pop) begin
      stack_count  <= stack_count - 1'b1;
      valid_so_far <= 1'b0;
    end else if (cmd.sq_clear) begin
      in_sq        <= 1'b0;
      valid_so_far <= 1'b0;
    end else if (cmd.dq_clear) begin
      in_dq        <= 1'b0;
      valid_so_far <= 1'b0;
    end else if (cmd.summary) begin
      stack_count  <= '0;
      byte_index   <= '0;
      in_sq        <= 1'b0;
      in_dq        <= 1'b0;
      valid_so_far <= 1'b1;
    end
  end

  // Output register
  logic load;
  assign load = (cmd.take && (closer_bad || push_full)) || cmd.pop ||
                cmd.sq_clear || cmd.dq_clear || cmd.summary;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code      <= CODE_SUMMARY;
      out_bracket   <= 8'h00;
      out_position  <= '0;
      out_all_valid <= 1'b0;
      out_last      <= 1'b0;
      if (cmd.take) begin
        out_code     <= closer_bad ? CODE_CLOSER : CODE_OVERFLOW;
        out_bracket  <= ch;
        out_position <= byte_index;
      end else if (cmd.pop) begin
        out_code     <= CODE_OPENER;
        out_bracket  <= stk_char[top_idx];
        out_position <= stk_pos[top_idx];
      end else if (cmd.sq_clear) begin
        out_code <= CODE_SQ_OPEN;
      end else if (cmd.dq_clear) begin
        out_code <= CODE_DQ_OPEN;
      end else begin
        out_all_valid <= valid_so_far;
        out_last      <= 1'b1;
      end
    end
  end

endmodule

### src/bqbc_ctrl.sv
// ----------------------------------------------------------------------------
// bqbc_ctrl
// Controller: accepts bytes and sequences the end-of-string flush.
// ----------------------------------------------------------------------------
module bqbc_ctrl
  import bqbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FLUSH = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;

  assign slot_free = !status.out_busy || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          if (!status.stack_empty) begin
            cmd.pop = 1'b1;
          end else if (status.in_sq) begin
            cmd.sq_clear = 1'b1;
          end else if (status.in_dq) begin
            cmd.dq_clear = 1'b1;
          end else begin
            cmd.summary = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> !in_ready)
    else $error("input accepted during flush");

  a_summary_ends_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.summary |=> (state == S_IDLE) && status.stack_empty && !status.in_sq && !status.in_dq)
    else $error("state not cleared after summary");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && in_last) |=> (state == S_FLUSH))
    else $error("flush not started after last byte");

endmodule

### src/bracket_quote_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_quote_balance_checker
// Checks bracket balance of a byte stream, with quotes suspending the check.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output side keeps up.
// Reports: a closer or overflow report appears on m_* in the cycle after its byte.
// End of string: input holds off while the flush runs, which reports each unmatched
//   opener, then an open quote if any, then the summary (output stall extends it).
// Reset: clears stack count, quote flags, byte index and the valid flag; the
//   opener stack storage is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module bracket_quote_balance_checker
  import bqbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input bytes
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] ch
  input  logic               s_tlast,   // last_char
  // Results
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] bracket, [23:8] position,
                                        // [24] all_valid, [31:25] zero
  output logic [CODE_W-1:0]  m_tuser,   // [2:0] code
  output logic               m_tlast    // last_result
);

  cmd_t              cmd;
  status_t           status;
  logic [7:0]        res_bracket;
  logic [POS_W-1:0]  res_position;
  logic              res_all_valid;

  // Controller: accept bytes while idle, then walk the flush sequence
  bqbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: stack, quote tracking and the registered result
  bqbc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .ch            (s_tdata),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_code      (m_tuser),
    .out_bracket   (res_bracket),
    .out_position  (res_position),
    .out_all_valid (res_all_valid),
    .out_last      (m_tlast)
  );

  // Pack the result fields, lowest field first, zero fill to the word width
  assign m_tdata = {{(TDATA_W - 8 - POS_W - 1){1'b0}}, res_all_valid,
                    res_position, res_bracket};

endmodule
